@@ rtl/core/qsn_pkg.sv @@
package qsn_pkg;

  localparam int DIV_W  = 35;
  localparam int SPAN_W = 15;

  localparam logic signed [31:0] PEAK_POTENTIAL = 32'sd2293760;

  localparam logic signed [31:0] RATE_RESET   = 32'sd1966;
  localparam logic signed [31:0] SENS_RESET   = -32'sd131072;
  localparam logic signed [31:0] VRESET_RESET = -32'sd3276800;
  localparam logic signed [31:0] INCR_RESET   = 32'sd6553600;
  localparam logic signed [31:0] GAIN_RESET   = 32'sd45875;
  localparam logic signed [31:0] REST_RESET   = -32'sd3932160;
  localparam logic signed [31:0] THR_RESET    = -32'sd2621440;
  localparam logic [SPAN_W-1:0]  SPAN_RESET   = 15'd1;

  localparam logic [2:0] REG_RATE   = 3'd0;
  localparam logic [2:0] REG_SENS   = 3'd1;
  localparam logic [2:0] REG_VRESET = 3'd2;
  localparam logic [2:0] REG_INCR   = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_REST   = 3'd5;
  localparam logic [2:0] REG_THR    = 3'd6;
  localparam logic [2:0] REG_SPAN   = 3'd7;

  typedef enum logic [1:0] {
    MODE_EULER   = 2'd0,
    MODE_RK4     = 2'd1,
    MODE_COUNTS  = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MOD, OP_NOISE, OP_MUL_K, OP_MUL_Q, OP_MUL_B, OP_MUL_A,
    OP_SAT, OP_FA, OP_EULER_V, OP_EULER_U, OP_ACC, OP_DIV_V, OP_APPLY_V,
    OP_DIV_U, OP_APPLY_U, OP_SPIKE, OP_RESTART, OP_OUT, OP_OUT_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic signed [31:0] recovery_rate;
    logic signed [31:0] recovery_sensitivity;
    logic signed [31:0] reset_potential;
    logic signed [31:0] reset_increment;
    logic signed [31:0] quadratic_gain;
    logic signed [31:0] rest_potential;
    logic signed [31:0] threshold_potential;
    logic [SPAN_W-1:0]  noise_span;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] inc_sat(input logic [31:0] x);
    return (x == 32'hffffffff) ? x : x + 32'd1;
  endfunction

endpackage

@@ rtl/core/quadratic_spiking_neuron_step_top.sv @@
// quadratic spiking neuron, one transaction per neuron step
// input channel: in_valid/in_ready with in_mode and the drive and random words;
//   mode 0 euler step, 1 rk4 step, 2 read and clear counts, 3 restart
// result channel: out_valid/out_ready, one result per input transaction
// config channel: cfg_valid/cfg_ready, always ready, cfg_index selects the register
// one transaction at a time; a shared 32x32 multiplier, a bit-serial divider
//   for the noise modulo and a two-step reciprocal multiply for the division
//   by six set the latency
// the next input is taken once the result sits in the output register,
//   even while the receiver has not yet taken it
// when the receiver stalls the result is held and a finished step waits
//   until the output register is free
// synchronous reset restores register defaults, potential to rest,
//   recovery and counts to zero; no result is pending after reset
module quadratic_spiking_neuron_step_top
  import qsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_drive_current,
  input  logic [30:0]        in_random_first,
  input  logic [30:0]        in_random_second,
  input  logic [30:0]        in_random_third,
  input  logic [30:0]        in_random_fourth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_membrane_out,
  output logic signed [31:0] out_recovery_out,
  output logic               out_fired,
  output logic [31:0]        out_spikes_seen,
  output logic [31:0]        out_steps_seen,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recovery_rate        <= RATE_RESET;
      cfg_r.recovery_sensitivity <= SENS_RESET;
      cfg_r.reset_potential      <= VRESET_RESET;
      cfg_r.reset_increment      <= INCR_RESET;
      cfg_r.quadratic_gain       <= GAIN_RESET;
      cfg_r.rest_potential       <= REST_RESET;
      cfg_r.threshold_potential  <= THR_RESET;
      cfg_r.noise_span           <= SPAN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RATE:   cfg_r.recovery_rate        <= cfg_data;
        REG_SENS:   cfg_r.recovery_sensitivity <= cfg_data;
        REG_VRESET: cfg_r.reset_potential      <= cfg_data;
        REG_INCR:   cfg_r.reset_increment      <= cfg_data;
        REG_GAIN:   cfg_r.quadratic_gain       <= cfg_data;
        REG_REST:   cfg_r.rest_potential       <= cfg_data;
        REG_THR:    cfg_r.threshold_potential  <= cfg_data;
        REG_SPAN:   cfg_r.noise_span           <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  qsn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qsn_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .stat             (stat),
    .in_drive_current (in_drive_current),
    .in_random_first  (in_random_first),
    .in_random_second (in_random_second),
    .in_random_third  (in_random_third),
    .in_random_fourth (in_random_fourth),
    .out_membrane_out (out_membrane_out),
    .out_recovery_out (out_recovery_out),
    .out_fired        (out_fired),
    .out_spikes_seen  (out_spikes_seen),
    .out_steps_seen   (out_steps_seen)
  );

endmodule

@@ rtl/core/qsn_div.sv @@
module qsn_div
  import qsn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [SPAN_W-1:0] divisor,
  output logic [SPAN_W-1:0] rem,
  output logic              done
);

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [SPAN_W-1:0] dvs_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              take;

  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
        dvd_r <= {dvd_r[DIV_W-2:0], take};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

@@ rtl/core/qsn_datapath.sv @@
module qsn_datapath
  import qsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic signed [31:0] in_drive_current,
  input  logic [30:0]        in_random_first,
  input  logic [30:0]        in_random_second,
  input  logic [30:0]        in_random_third,
  input  logic [30:0]        in_random_fourth,
  output logic signed [31:0] out_membrane_out,
  output logic signed [31:0] out_recovery_out,
  output logic               out_fired,
  output logic [31:0]        out_spikes_seen,
  output logic [31:0]        out_steps_seen
);

  // ceil(2^23 / 6), exact for dividends below 2^20
  localparam logic [20:0] D6_RECIP = 21'd1398102;

  logic signed [31:0] v_r, u_r, tv_r, tu_r, cur_r, p_r;
  logic [31:0]        sp_r, st_r;
  logic [30:0]        raw_r [4];
  logic signed [63:0] prod_r;
  logic signed [15:0] noise_r;
  logic signed [34:0] fa_r;
  logic signed [35:0] accv_r, accu_r;
  logic               sign_r, fired_r;

  logic signed [31:0] mul_a, mul_b, fas, vn, tv_half, tu_half;
  logic signed [34:0] fa_nxt;
  logic signed [35:0] addv, addu, qs;
  logic [SPAN_W-1:0]  span_eff, div_dvs, div_rem;
  logic [DIV_W-1:0]   div_dvd, absv, absu;
  logic               div_start, div_done, w2;

  // division by six in two steps: high part, then remainder with low part
  logic [DIV_W-1:0]   d6_x;
  logic [38:0]        d6_p1;
  logic [15:0]        d6_qh;
  logic [17:0]        d6_rh;
  logic [19:0]        d6_y;
  logic [40:0]        d6_p2;
  logic [15:0]        d6_qh_r;
  logic [2:0]         d6_rh_r;
  logic [16:0]        d6_xl_r;
  logic [DIV_W-1:0]   d6_q_r;
  logic               d6_busy_r, d6_done_r;

  assign span_eff = (cfg.noise_span == '0) ? SPAN_W'(1) : cfg.noise_span;
  assign absv = accv_r[35] ? DIV_W'(-accv_r) : accv_r[DIV_W-1:0];
  assign absu = accu_r[35] ? DIV_W'(-accu_r) : accu_r[DIV_W-1:0];

  assign div_start = (cmd.op == OP_MOD);
  assign div_dvd   = DIV_W'(raw_r[cmd.stage]);
  assign div_dvs   = span_eff;

  qsn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .rem      (div_rem),
    .done     (div_done)
  );

  always_comb begin
    d6_x  = (cmd.op == OP_DIV_V) ? absv : absu;
    d6_p1 = 39'(d6_x[DIV_W-1:17]) * 39'(D6_RECIP);
    d6_qh = d6_p1[38:23];
    d6_rh = d6_x[DIV_W-1:17] - ({d6_qh, 2'b0} + {1'b0, d6_qh, 1'b0});
    d6_y  = {d6_rh_r, d6_xl_r};
    d6_p2 = 41'(d6_y) * 41'(D6_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d6_busy_r <= 1'b0;
      d6_done_r <= 1'b0;
    end else begin
      d6_busy_r <= (cmd.op == OP_DIV_V) || (cmd.op == OP_DIV_U);
      d6_done_r <= d6_busy_r;
      if ((cmd.op == OP_DIV_V) || (cmd.op == OP_DIV_U)) begin
        d6_qh_r <= d6_qh;
        d6_rh_r <= d6_rh[2:0];
        d6_xl_r <= d6_x[16:0];
      end
      if (d6_busy_r) begin
        d6_q_r <= DIV_W'({d6_qh_r, 17'b0}) + DIV_W'(d6_p2[40:23]);
      end
    end
  end

  assign stat.div_done = div_done | d6_done_r;

  always_comb begin
    mul_a = cfg.quadratic_gain;
    mul_b = sat32(64'(tv_r) - 64'(cfg.rest_potential));
    case (cmd.op)
      OP_MUL_Q: begin
        mul_a = p_r;
        mul_b = sat32(64'(tv_r) - 64'(cfg.threshold_potential));
      end
      OP_MUL_B: mul_a = cfg.recovery_sensitivity;
      OP_MUL_A: begin
        mul_a = cfg.recovery_rate;
        mul_b = sat32(64'(p_r) - 64'(tu_r));
      end
      default: ;
    endcase
  end

  always_comb begin
    fa_nxt  = 35'(p_r) - 35'(tu_r) + 35'(cur_r) + (35'(noise_r) <<< 16);
    fas     = sat32(64'(fa_r));
    vn      = sat32(64'(v_r) + 64'(fa_r));
    w2      = (cmd.stage == 2'd1) || (cmd.stage == 2'd2);
    addv    = 36'(fas);
    addu    = 36'(p_r);
    if (w2) begin
      addv = addv <<< 1;
      addu = addu <<< 1;
    end
    tv_half = (cmd.stage == 2'd2) ? fas : (fas >>> 1);
    tu_half = (cmd.stage == 2'd2) ? p_r : (p_r >>> 1);
    qs      = sign_r ? -$signed({1'b0, d6_q_r}) : $signed({1'b0, d6_q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= REST_RESET;
      u_r     <= '0;
      sp_r    <= '0;
      st_r    <= '0;
      fired_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          cur_r    <= in_drive_current;
          raw_r[0] <= in_random_first;
          raw_r[1] <= in_random_second;
          raw_r[2] <= in_random_third;
          raw_r[3] <= in_random_fourth;
          tv_r     <= v_r;
          tu_r     <= u_r;
          accv_r   <= '0;
          accu_r   <= '0;
          fired_r  <= 1'b0;
        end
        OP_NOISE: noise_r <= $signed({1'b0, div_rem}) - $signed({2'b0, span_eff[SPAN_W-1:1]});
        OP_MUL_K, OP_MUL_Q, OP_MUL_B, OP_MUL_A: prod_r <= mul_a * mul_b;
        OP_SAT: p_r <= sat32(prod_r >>> 16);
        OP_FA: fa_r <= fa_nxt;
        OP_EULER_V: begin
          v_r  <= vn;
          tv_r <= vn;
        end
        OP_EULER_U: u_r <= sat32(64'(u_r) + 64'(p_r));
        OP_ACC: begin
          accv_r <= accv_r + addv;
          accu_r <= accu_r + addu;
          tv_r   <= sat32(64'(v_r) + 64'(tv_half));
          tu_r   <= sat32(64'(u_r) + 64'(tu_half));
        end
        OP_DIV_V: sign_r <= accv_r[35];
        OP_DIV_U: sign_r <= accu_r[35];
        OP_APPLY_V: v_r <= sat32(64'(v_r) + 64'(qs));
        OP_APPLY_U: u_r <= sat32(64'(u_r) + 64'(qs));
        OP_SPIKE: begin
          if (v_r > PEAK_POTENTIAL) begin
            fired_r <= 1'b1;
            sp_r    <= inc_sat(sp_r);
            v_r     <= cfg.reset_potential;
            u_r     <= sat32(64'(u_r) + 64'(cfg.reset_increment));
          end
          st_r <= inc_sat(st_r);
        end
        OP_RESTART: begin
          v_r  <= cfg.rest_potential;
          u_r  <= '0;
          st_r <= '0;
        end
        OP_OUT, OP_OUT_CLEAR: begin
          out_membrane_out <= v_r;
          out_recovery_out <= u_r;
          out_fired        <= fired_r;
          out_spikes_seen  <= sp_r;
          out_steps_seen   <= st_r;
          if (cmd.op == OP_OUT_CLEAR) begin
            sp_r <= '0;
            st_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/qsn_ctrl.sv @@
module qsn_ctrl
  import qsn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_MOD, S_MOD_WAIT, S_NOISE, S_MUL_K, S_SAT_K, S_MUL_Q, S_SAT_Q, S_FA,
    S_EULER_V, S_MUL_B, S_SAT_B, S_MUL_A, S_SAT_A, S_EULER_U, S_ACC, S_DIV_V,
    S_DIV_V_WAIT, S_APPLY_V, S_DIV_U, S_DIV_U_WAIT, S_APPLY_U, S_SPIKE, S_RESTART,
    S_OUT
  } state_t;

  state_t     state_r;
  mode_t      mode_r;
  logic [1:0] stage_r;
  logic       out_valid_r;
  logic       out_free;
  logic       euler;

  assign out_free  = !out_valid_r || out_ready;
  assign euler     = (mode_r == MODE_EULER);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.stage = stage_r;
    unique case (state_r)
      S_IDLE:       cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_MOD:        cmd.op = OP_MOD;
      S_NOISE:      cmd.op = OP_NOISE;
      S_MUL_K:      cmd.op = OP_MUL_K;
      S_MUL_Q:      cmd.op = OP_MUL_Q;
      S_MUL_B:      cmd.op = OP_MUL_B;
      S_MUL_A:      cmd.op = OP_MUL_A;
      S_SAT_K, S_SAT_Q, S_SAT_B, S_SAT_A: cmd.op = OP_SAT;
      S_FA:         cmd.op = OP_FA;
      S_EULER_V:    cmd.op = OP_EULER_V;
      S_EULER_U:    cmd.op = OP_EULER_U;
      S_ACC:        cmd.op = OP_ACC;
      S_DIV_V:      cmd.op = OP_DIV_V;
      S_APPLY_V:    cmd.op = OP_APPLY_V;
      S_DIV_U:      cmd.op = OP_DIV_U;
      S_APPLY_U:    cmd.op = OP_APPLY_U;
      S_SPIKE:      cmd.op = OP_SPIKE;
      S_RESTART:    cmd.op = OP_RESTART;
      S_OUT: begin
        if (!out_free) begin
          cmd.op = OP_NONE;
        end else begin
          cmd.op = (mode_r == MODE_COUNTS) ? OP_OUT_CLEAR : OP_OUT;
        end
      end
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_EULER;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= mode_t'(in_mode);
            stage_r <= '0;
            unique case (mode_t'(in_mode))
              MODE_EULER, MODE_RK4: state_r <= S_MOD;
              MODE_COUNTS:          state_r <= S_OUT;
              MODE_RESTART:         state_r <= S_RESTART;
              default:              state_r <= S_OUT;
            endcase
          end
        end
        S_MOD:      state_r <= S_MOD_WAIT;
        S_MOD_WAIT: if (stat.div_done) state_r <= S_NOISE;
        S_NOISE:    state_r <= S_MUL_K;
        S_MUL_K:    state_r <= S_SAT_K;
        S_SAT_K:    state_r <= S_MUL_Q;
        S_MUL_Q:    state_r <= S_SAT_Q;
        S_SAT_Q:    state_r <= S_FA;
        S_FA:       state_r <= euler ? S_EULER_V : S_MUL_B;
        S_EULER_V:  state_r <= S_MUL_B;
        S_MUL_B:    state_r <= S_SAT_B;
        S_SAT_B:    state_r <= S_MUL_A;
        S_MUL_A:    state_r <= S_SAT_A;
        S_SAT_A:    state_r <= euler ? S_EULER_U : S_ACC;
        S_EULER_U:  state_r <= S_SPIKE;
        S_ACC: begin
          if (stage_r == 2'd3) begin
            state_r <= S_DIV_V;
          end else begin
            stage_r <= stage_r + 2'd1;
            state_r <= S_MOD;
          end
        end
        S_DIV_V:      state_r <= S_DIV_V_WAIT;
        S_DIV_V_WAIT: if (stat.div_done) state_r <= S_APPLY_V;
        S_APPLY_V:    state_r <= S_DIV_U;
        S_DIV_U:      state_r <= S_DIV_U_WAIT;
        S_DIV_U_WAIT: if (stat.div_done) state_r <= S_APPLY_U;
        S_APPLY_U:    state_r <= S_SPIKE;
        S_SPIKE:      state_r <= S_OUT;
        S_RESTART:    state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_MOD_WAIT || state_r == S_DIV_V_WAIT ||
                       state_r == S_DIV_U_WAIT))
    else $error("divider finished outside a wait state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT && out_valid_r))
    else $error("result overwritten while receiver stalls");

endmodule

@@ sim/tb_quadratic_spiking_neuron_step_top.sv @@
module tb_quadratic_spiking_neuron_step_top
  import qsn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_mode;
  logic signed [31:0] in_drive_current;
  logic [30:0] in_random_first;
  logic [30:0] in_random_second;
  logic [30:0] in_random_third;
  logic [30:0] in_random_fourth;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_membrane_out;
  logic signed [31:0] out_recovery_out;
  logic out_fired;
  logic [31:0] out_spikes_seen;
  logic [31:0] out_steps_seen;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  quadratic_spiking_neuron_step_top dut (.*);

  typedef struct {
    logic signed [31:0] membrane;
    logic signed [31:0] recovery;
    logic fired;
    logic [31:0] spikes;
    logic [31:0] steps;
  } neuron_result_t;

  neuron_result_t expected_q[$];

  // predictor state
  logic signed [31:0] p_rate, p_sens, p_vreset, p_incr, p_gain, p_rest, p_thr;
  logic [14:0] p_span;
  longint p_v, p_u;
  logic [31:0] p_spikes, p_steps;

  int errors;
  int sent;
  int received;
  int fired_count;
  int mode_count[4];
  int idle_cycles;
  bit stalls_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint half_floor(input longint x);
    return x >>> 1;
  endfunction

  function automatic longint fx_mul(input longint x, input longint y);
    longint p;
    p = x * y;
    return clamp32(p >>> 16);
  endfunction

  function automatic longint noise_mv(input logic [30:0] raw);
    longint span;
    span = (p_span == 0) ? 1 : longint'(p_span);
    return (longint'(raw) % span) - span / 2;
  endfunction

  function automatic longint dv_of(input longint v, input longint u, input longint cur,
                                   input logic [30:0] raw);
    longint d1, d2, q;
    d1 = clamp32(v - longint'(p_rest));
    d2 = clamp32(v - longint'(p_thr));
    q = fx_mul(fx_mul(longint'(p_gain), d1), d2);
    return q - u + cur + noise_mv(raw) * 65536;
  endfunction

  function automatic longint du_of(input longint v, input longint u);
    longint t1, t3;
    t1 = clamp32(v - longint'(p_rest));
    t3 = clamp32(fx_mul(longint'(p_sens), t1) - u);
    return fx_mul(longint'(p_rate), t3);
  endfunction

  function automatic logic check_spike();
    logic f;
    f = 1'b0;
    if (p_v > longint'(PEAK_POTENTIAL)) begin
      f = 1'b1;
      if (p_spikes != 32'hffffffff) p_spikes = p_spikes + 1;
      p_v = longint'(p_vreset);
      p_u = clamp32(p_u + longint'(p_incr));
    end
    if (p_steps != 32'hffffffff) p_steps = p_steps + 1;
    return f;
  endfunction

  function automatic void predict_neuron(input logic [1:0] mode, input logic signed [31:0] cur,
                                         input logic [30:0] r0, input logic [30:0] r1,
                                         input logic [30:0] r2, input logic [30:0] r3);
    neuron_result_t r;
    longint fa[4], fb[4];
    logic [30:0] raws[4];
    longint tv, tu, c;
    c = longint'(cur);
    raws[0] = r0; raws[1] = r1; raws[2] = r2; raws[3] = r3;
    r.fired = 1'b0;
    case (mode)
      MODE_EULER: begin
        p_v = clamp32(p_v + dv_of(p_v, p_u, c, r0));
        p_u = clamp32(p_u + du_of(p_v, p_u));
        r.fired = check_spike();
      end
      MODE_RK4: begin
        for (int i = 0; i < 4; i++) begin
          tv = p_v;
          tu = p_u;
          if (i == 1 || i == 2) begin
            tv = clamp32(p_v + half_floor(fa[i-1]));
            tu = clamp32(p_u + half_floor(fb[i-1]));
          end else if (i == 3) begin
            tv = clamp32(p_v + fa[2]);
            tu = clamp32(p_u + fb[2]);
          end
          fa[i] = clamp32(dv_of(tv, tu, c, raws[i]));
          fb[i] = du_of(tv, tu);
        end
        p_v = clamp32(p_v + (fa[0] + 2 * fa[1] + 2 * fa[2] + fa[3]) / 6);
        p_u = clamp32(p_u + (fb[0] + 2 * fb[1] + 2 * fb[2] + fb[3]) / 6);
        r.fired = check_spike();
      end
      MODE_RESTART: begin
        p_v = longint'(p_rest);
        p_u = 0;
        p_steps = 0;
      end
      default: ;
    endcase
    r.spikes = p_spikes;
    r.steps = p_steps;
    if (mode == MODE_COUNTS) begin
      p_spikes = 0;
      p_steps = 0;
    end
    r.membrane = p_v[31:0];
    r.recovery = p_u[31:0];
    if (r.fired) fired_count++;
    expected_q.push_back(r);
  endfunction

  function automatic void predictor_reset();
    p_rate = RATE_RESET; p_sens = SENS_RESET; p_vreset = VRESET_RESET;
    p_incr = INCR_RESET; p_gain = GAIN_RESET; p_rest = REST_RESET;
    p_thr = THR_RESET; p_span = SPAN_RESET;
    p_v = longint'(REST_RESET);
    p_u = 0;
    p_spikes = 0;
    p_steps = 0;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result checker
  always @(posedge clk) begin
    neuron_result_t e;
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction membrane %h", $time, out_membrane_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_membrane_out !== e.membrane) begin
          $display("%0t: membrane expected %h actual %h", $time, e.membrane, out_membrane_out);
          errors++;
        end
        if (out_recovery_out !== e.recovery) begin
          $display("%0t: recovery expected %h actual %h", $time, e.recovery, out_recovery_out);
          errors++;
        end
        if (out_fired !== e.fired) begin
          $display("%0t: fired expected %b actual %b", $time, e.fired, out_fired);
          errors++;
        end
        if (out_spikes_seen !== e.spikes) begin
          $display("%0t: spikes expected %0d actual %0d", $time, e.spikes, out_spikes_seen);
          errors++;
        end
        if (out_steps_seen !== e.steps) begin
          $display("%0t: steps expected %0d actual %0d", $time, e.steps, out_steps_seen);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 60);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic signed [31:0] cur,
                           input logic [30:0] r0, input logic [30:0] r1,
                           input logic [30:0] r2, input logic [30:0] r3);
    int g;
    g = gap_length();
    repeat (g + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_drive_current <= cur;
    in_random_first <= r0;
    in_random_second <= r1;
    in_random_third <= r2;
    in_random_fourth <= r3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_neuron(mode, cur, r0, r1, r2, r3);
    sent++;
    mode_count[mode]++;
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RATE: p_rate = data;
      REG_SENS: p_sens = data;
      REG_VRESET: p_vreset = data;
      REG_INCR: p_incr = data;
      REG_GAIN: p_gain = data;
      REG_REST: p_rest = data;
      REG_THR: p_thr = data;
      default: p_span = data[14:0];
    endcase
    @(posedge clk);
  endtask

  task automatic write_defaults();
    write_reg(REG_RATE, RATE_RESET);
    write_reg(REG_SENS, SENS_RESET);
    write_reg(REG_VRESET, VRESET_RESET);
    write_reg(REG_INCR, INCR_RESET);
    write_reg(REG_GAIN, GAIN_RESET);
    write_reg(REG_REST, REST_RESET);
    write_reg(REG_THR, THR_RESET);
    write_reg(REG_SPAN, 32'(SPAN_RESET));
  endtask

  function automatic logic [30:0] rand31();
    return 31'($urandom());
  endfunction

  function automatic logic signed [31:0] plausible_current();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $signed(32'($urandom_range(0, 40 * 65536))) - 32'sd655360;
    if (r < 9) return $signed(32'($urandom_range(0, 400 * 65536)));
    return $signed($urandom());
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return MODE_EULER;
    if (r < 88) return MODE_RK4;
    if (r < 95) return MODE_COUNTS;
    return MODE_RESTART;
  endfunction

  task automatic test_directed_modes();
    send_item(MODE_COUNTS, 0, 0, 0, 0, 0);
    send_item(MODE_EULER, 0, 0, 0, 0, 0);
    send_item(MODE_RK4, 0, 31'h7fffffff, 0, 31'h7fffffff, 0);
    send_item(MODE_EULER, 32'sh7fffffff, 31'h7fffffff, 0, 0, 0);
    send_item(MODE_EULER, 32'sh80000000, 0, 0, 0, 0);
    send_item(MODE_RK4, 32'sh7fffffff, 31'h55555555, 31'h2aaaaaaa, 31'h7fffffff, 31'h0);
    send_item(MODE_RK4, 32'sh80000000, 0, 31'h7fffffff, 0, 31'h7fffffff);
    send_item(MODE_RESTART, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
              31'h7fffffff);
    // drive strong enough to fire
    for (int i = 0; i < 6; i++) send_item(MODE_EULER, 32'sd30 * 65536, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_item(MODE_RK4, 32'sd30 * 65536, 0, 0, 0, 0);
    send_item(MODE_COUNTS, 0, 0, 0, 0, 0);
    send_item(MODE_COUNTS, 0, 0, 0, 0, 0);
    send_item(MODE_RESTART, 0, 0, 0, 0, 0);
  endtask

  task automatic test_noise_spans();
    wait_drained();
    write_reg(REG_SPAN, 32'd0);
    send_item(MODE_EULER, 0, 31'h7fffffff, 0, 0, 0);
    wait_drained();
    write_reg(REG_SPAN, 32'h7fff);
    send_item(MODE_EULER, 0, 31'h7fffffff, 0, 0, 0);
    send_item(MODE_RK4, 0, 31'h12345678, 31'h7ffe, 31'h0, 31'h7fffffff);
    send_item(MODE_RESTART, 0, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_SPAN, 32'hffff_8007);
    send_item(MODE_EULER, 0, rand31(), 0, 0, 0);
    send_item(MODE_RESTART, 0, 0, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    logic [31:0] ext[4];
    ext[0] = 32'h7fffffff; ext[1] = 32'h80000000; ext[2] = 32'h0; ext[3] = 32'hffffffff;
    for (int s = 0; s < 4; s++) begin
      wait_drained();
      for (int i = 0; i < 7; i++) write_reg(3'(i), ext[(s + i) % 4]);
      for (int n = 0; n < 12; n++) begin
        send_item(pick_mode(), $signed($urandom()), rand31(), rand31(), rand31(), rand31());
      end
    end
    wait_drained();
    write_defaults();
    send_item(MODE_RESTART, 0, 0, 0, 0, 0);
  endtask

  task automatic random_phase(input int count, input bit random_regs);
    wait_drained();
    if (random_regs) begin
      write_reg(REG_RATE, $urandom_range(0, 6000));
      write_reg(REG_SENS, -$urandom_range(0, 300000));
      write_reg(REG_VRESET, -$urandom_range(2000000, 4500000));
      write_reg(REG_INCR, $urandom_range(0, 8000000));
      write_reg(REG_GAIN, $urandom_range(20000, 80000));
      write_reg(REG_REST, -$urandom_range(3500000, 4500000));
      write_reg(REG_THR, -$urandom_range(2000000, 3000000));
      write_reg(REG_SPAN, $urandom_range(1, 40));
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(2'($urandom_range(0, 3)), $signed($urandom()), rand31(), rand31(), rand31(),
                  rand31());
      end else begin
        send_item(pick_mode(), plausible_current(), rand31(), rand31(), rand31(), rand31());
      end
    end
  endtask

  task automatic test_pause_until_drained();
    for (int n = 0; n < 10; n++) begin
      send_item(MODE_EULER, plausible_current(), rand31(), 0, 0, 0);
      if (n % 3 == 0) wait_drained();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_EULER;
    in_drive_current = '0;
    in_random_first = '0;
    in_random_second = '0;
    in_random_third = '0;
    in_random_fourth = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    sent = 0;
    received = 0;
    fired_count = 0;
    idle_cycles = 0;
    stalls_on = 1'b0;
    for (int i = 0; i < 4; i++) mode_count[i] = 0;
    predictor_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_modes();
    stalls_on = 1'b1;
    test_noise_spans();
    test_register_extremes();
    test_pause_until_drained();
    stalls_on = 1'b0;
    random_phase(150, 1'b0);
    stalls_on = 1'b1;
    for (int p = 0; p < 5; p++) random_phase(130, 1'b1);
    random_phase(60, 1'b0);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d transactions (euler %0d, rk4 %0d, counts %0d, restart %0d)",
             sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("checked %0d results, %0d spikes predicted, %0d mismatches",
             received, fired_count, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
